[sv/http_request_header_parser_defines.svh]
// Assertion macros used by the parser engine RTL.
`ifndef HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRP_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hrp_pkg.sv]
// Shared types, codes and byte classification for the HTTP request parser.
`default_nettype none
package hrp_pkg;

  localparam logic [1:0] STAT_MORE = 2'd0;
  localparam logic [1:0] STAT_GOOD = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [2:0] CL_DELIM  = 3'd0;
  localparam logic [2:0] CL_METHOD = 3'd1;
  localparam logic [2:0] CL_PATH   = 3'd2;
  localparam logic [2:0] CL_KEY    = 3'd3;
  localparam logic [2:0] CL_VALUE  = 3'd4;
  localparam logic [2:0] CL_HNAME  = 3'd5;
  localparam logic [2:0] CL_HVALUE = 3'd6;

  localparam logic CMD_PARSE   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CTL_MAX  = 8'h1F;
  localparam logic [11:0] VER_MAX = 12'd255;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] byte_class;
    logic       new_entry;
    logic [7:0] out_byte;
    logic [7:0] major_version;
    logic [7:0] minor_version;
  } res_item_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= CTL_MAX) || (b == CH_DEL);
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    logic r;
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Bytes with the top bit set are never token characters.
  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_special(b);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // value*10 + digit, saturating at 255.
  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] b);
    logic [11:0] r;
    r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, b[3:0]};
    return (r > VER_MAX) ? 8'hFF : r[7:0];
  endfunction

endpackage
`default_nettype wire

[sv/hrp_if.sv]
// Valid/ready channel interfaces for request bytes and parse results.
`default_nettype none
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] byte_class;
  logic       new_entry;
  logic [7:0] out_byte;
  logic [7:0] major_version;
  logic [7:0] minor_version;

  modport source (output valid, output status, output byte_class, output new_entry,
                  output out_byte, output major_version, output minor_version,
                  input ready);
  modport sink   (input valid, input status, input byte_class, input new_entry,
                  input out_byte, input major_version, input minor_version,
                  output ready);
endinterface
`default_nettype wire

[sv/hrp_in_reg.sv]
// Input register: captures one request transaction and holds it for the parser.
`default_nettype none
module hrp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  hrp_in_if.sink                 req,
  input  wire logic              advance,
  output logic                   item_valid,
  output hrp_pkg::req_item_t     item
);
  import hrp_pkg::*;

  // Take a new transaction whenever the register is empty or drains this cycle.
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.cmd     <= req.cmd;
      item.in_byte <= req.in_byte;
    end
  end
endmodule
`default_nettype wire

[sv/hrp_engine.sv]
// Parse state machine: one request byte per step, version counters and header flag.
`default_nettype none
`include "http_request_header_parser_defines.svh"
module hrp_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire hrp_pkg::req_item_t item,
  output hrp_pkg::res_item_t     res
);
  import hrp_pkg::*;

  typedef enum logic [4:0] {
    ST_METHOD_START  = 5'd0,
    ST_METHOD        = 5'd1,
    ST_URI_PATH      = 5'd2,
    ST_URI_KEY       = 5'd3,
    ST_URI_VALUE     = 5'd4,
    ST_VER_H         = 5'd5,
    ST_VER_T1        = 5'd6,
    ST_VER_T2        = 5'd7,
    ST_VER_P         = 5'd8,
    ST_VER_SLASH     = 5'd9,
    ST_MAJOR_START   = 5'd10,
    ST_MAJOR         = 5'd11,
    ST_MINOR_START   = 5'd12,
    ST_MINOR         = 5'd13,
    ST_NL1           = 5'd14,
    ST_LINE_START    = 5'd15,
    ST_LWS           = 5'd16,
    ST_HNAME         = 5'd17,
    ST_SP_BEFORE_VAL = 5'd18,
    ST_HVALUE        = 5'd19,
    ST_NL2           = 5'd20,
    ST_NL3           = 5'd21,
    ST_HELD_GOOD     = 5'd22,
    ST_HELD_BAD      = 5'd23
  } state_t;

  state_t     state, state_next;
  logic [7:0] major_count, major_count_next;
  logic [7:0] minor_count, minor_count_next;
  logic       header_seen, header_seen_next;
  logic       bad;
  logic [1:0] status;
  logic [2:0] cls;
  logic       entry;
  logic [7:0] b;

  assign b = item.in_byte;

  always_comb begin
    state_next       = state;
    major_count_next = major_count;
    minor_count_next = minor_count;
    header_seen_next = header_seen;
    status           = STAT_MORE;
    cls              = CL_DELIM;
    entry            = 1'b0;
    bad              = 1'b0;
    if (item.cmd == CMD_RESTART) begin
      state_next       = ST_METHOD_START;
      major_count_next = '0;
      minor_count_next = '0;
      header_seen_next = 1'b0;
    end else begin
      case (state)
        ST_METHOD_START: begin
          if (is_token(b)) begin
            state_next = ST_METHOD;
            cls        = CL_METHOD;
          end else bad = 1'b1;
        end
        ST_METHOD: begin
          if (b == CH_SP) state_next = ST_URI_PATH;
          else if (is_token(b)) cls = CL_METHOD;
          else bad = 1'b1;
        end
        ST_URI_PATH: begin
          if (b == CH_SP) state_next = ST_VER_H;
          else if (is_ctl(b)) bad = 1'b1;
          else if (b == CH_QUEST) begin
            state_next = ST_URI_KEY;
            entry      = 1'b1;
          end else cls = CL_PATH;
        end
        ST_URI_KEY: begin
          if (b == CH_SP) state_next = ST_VER_H;
          else if (is_ctl(b)) bad = 1'b1;
          else if (b == CH_EQ) state_next = ST_URI_VALUE;
          else cls = CL_KEY;
        end
        ST_URI_VALUE: begin
          if (b == CH_SP) state_next = ST_VER_H;
          else if (is_ctl(b)) bad = 1'b1;
          else if (b == CH_AMP) begin
            state_next = ST_URI_KEY;
            entry      = 1'b1;
          end else cls = CL_VALUE;
        end
        ST_VER_H: begin
          if (b == CH_H) state_next = ST_VER_T1; else bad = 1'b1;
        end
        ST_VER_T1: begin
          if (b == CH_T) state_next = ST_VER_T2; else bad = 1'b1;
        end
        ST_VER_T2: begin
          if (b == CH_T) state_next = ST_VER_P; else bad = 1'b1;
        end
        ST_VER_P: begin
          if (b == CH_P) state_next = ST_VER_SLASH; else bad = 1'b1;
        end
        ST_VER_SLASH: begin
          if (b == CH_SLASH) begin
            major_count_next = '0;
            minor_count_next = '0;
            state_next       = ST_MAJOR_START;
          end else bad = 1'b1;
        end
        ST_MAJOR_START: begin
          if (is_digit(b)) begin
            major_count_next = add_digit(major_count, b);
            state_next       = ST_MAJOR;
          end else bad = 1'b1;
        end
        ST_MAJOR: begin
          if (b == CH_DOT) state_next = ST_MINOR_START;
          else if (is_digit(b)) major_count_next = add_digit(major_count, b);
          else bad = 1'b1;
        end
        ST_MINOR_START: begin
          if (is_digit(b)) begin
            minor_count_next = add_digit(minor_count, b);
            state_next       = ST_MINOR;
          end else bad = 1'b1;
        end
        ST_MINOR: begin
          if (b == CH_CR) state_next = ST_NL1;
          else if (is_digit(b)) minor_count_next = add_digit(minor_count, b);
          else bad = 1'b1;
        end
        ST_NL1: begin
          if (b == CH_LF) state_next = ST_LINE_START; else bad = 1'b1;
        end
        ST_LINE_START: begin
          if (b == CH_CR) state_next = ST_NL3;
          else if (header_seen && (b == CH_SP || b == CH_TAB)) state_next = ST_LWS;
          else if (is_token(b)) begin
            header_seen_next = 1'b1;
            state_next       = ST_HNAME;
            cls              = CL_HNAME;
            entry            = 1'b1;
          end else bad = 1'b1;
        end
        ST_LWS: begin
          if (b == CH_CR) state_next = ST_NL2;
          else if (b == CH_SP || b == CH_TAB) state_next = ST_LWS;
          else if (is_ctl(b)) bad = 1'b1;
          else begin
            state_next = ST_HVALUE;
            cls        = CL_HVALUE;
          end
        end
        ST_HNAME: begin
          if (b == CH_COLON) state_next = ST_SP_BEFORE_VAL;
          else if (is_token(b)) cls = CL_HNAME;
          else bad = 1'b1;
        end
        ST_SP_BEFORE_VAL: begin
          if (b == CH_SP) state_next = ST_HVALUE; else bad = 1'b1;
        end
        ST_HVALUE: begin
          if (b == CH_CR) state_next = ST_NL2;
          else if (is_ctl(b)) bad = 1'b1;
          else cls = CL_HVALUE;
        end
        ST_NL2: begin
          if (b == CH_LF) state_next = ST_LINE_START; else bad = 1'b1;
        end
        ST_NL3: begin
          if (b == CH_LF) begin
            state_next = ST_HELD_GOOD;
            status     = STAT_GOOD;
          end else bad = 1'b1;
        end
        ST_HELD_GOOD: begin
          status = STAT_GOOD;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        state_next = ST_HELD_BAD;
        status     = STAT_BAD;
        cls        = CL_DELIM;
        entry      = 1'b0;
      end
    end
  end

  assign res.status        = status;
  assign res.byte_class    = cls;
  assign res.new_entry     = entry;
  assign res.out_byte      = (item.cmd == CMD_RESTART) ? 8'd0 : b;
  assign res.major_version = major_count_next;
  assign res.minor_version = minor_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_METHOD_START;
      major_count <= '0;
      minor_count <= '0;
      header_seen <= 1'b0;
    end else if (fire) begin
      state       <= state_next;
      major_count <= major_count_next;
      minor_count <= minor_count_next;
      header_seen <= header_seen_next;
    end
  end

  `HRP_ASSERT_NEXT(a_restart_clears, clk, rst, fire && item.cmd == CMD_RESTART,
    state == ST_METHOD_START && major_count == 8'd0 && minor_count == 8'd0 && !header_seen,
    "restart did not clear parser state")
  `HRP_ASSERT_SAME(a_held_bad_sticks, clk, rst,
    fire && item.cmd == CMD_PARSE && state == ST_HELD_BAD,
    res.status == STAT_BAD && res.byte_class == CL_DELIM && state_next == ST_HELD_BAD,
    "held bad state left without restart")
  `HRP_ASSERT_SAME(a_entry_source, clk, rst, fire && res.new_entry,
    res.status == STAT_MORE &&
    (state == ST_URI_PATH || state == ST_URI_VALUE || state == ST_LINE_START),
    "new entry mark from unexpected state")
  `HRP_ASSERT_NEXT(a_idle_holds, clk, rst, !fire,
    $stable(state) && $stable(major_count) && $stable(minor_count) && $stable(header_seen),
    "parser state moved without a transaction")
endmodule
`default_nettype wire

[sv/hrp_out_reg.sv]
// Result register: holds one parse result until the consumer takes it.
`default_nettype none
module hrp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hrp_pkg::res_item_t res_d,
  output logic                   can_take,
  hrp_out_if.source              res
);
  import hrp_pkg::*;

  res_item_t held;

  // Room when empty or when the current result leaves this cycle.
  assign can_take = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (can_take) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      held <= res_d;
    end
  end

  assign res.status        = held.status;
  assign res.byte_class    = held.byte_class;
  assign res.new_entry     = held.new_entry;
  assign res.out_byte      = held.out_byte;
  assign res.major_version = held.major_version;
  assign res.minor_version = held.minor_version;
endmodule
`default_nettype wire

[sv/http_request_header_parser.sv]
// Top level of the HTTP/1.1 request line and header parser.
`default_nettype none
// Streaming HTTP/1.1 request parser. Feed the request one byte per transaction
// on req (cmd 0 = parse in_byte, cmd 1 = restart for a new request); every
// transaction yields exactly one result on res carrying a status (more,
// complete, malformed), the class of the byte (method, path, query key/value,
// header name/value or delimiter), a mark on the byte that opens a query
// parameter or header, the echoed byte and the major/minor version parsed so
// far (saturating at 255). Once a request completes or turns out malformed the
// parser holds that status until a restart. Throughput is one byte per clock
// cycle, sustained, as long as res is drained. The input register loads at the
// accepting edge; the state transition then updates the parser state and loads
// the result register together, at an edge where the result register has
// room. That state transition is the only feedback loop and sets the rate.
// Strings are not stored and the URI is not percent-decoded.
module http_request_header_parser (
  input  wire logic clk,
  input  wire logic rst,
  hrp_in_if.sink    req,
  hrp_out_if.source res
);
  import hrp_pkg::*;

  logic      item_valid;
  req_item_t item;
  res_item_t step_res;
  logic      can_take;
  logic      fire;

  // Advance the parser when a byte waits and the result register has room.
  assign fire = item_valid && can_take;

  hrp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hrp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (step_res)
  );

  hrp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res_d    (step_res),
    .can_take (can_take),
    .res      (res)
  );
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the HTTP request header parser.
`timescale 1ns / 100ps

module testbench;
  import hrp_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int PHASE_LEN   = ITEM_TARGET / 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 8;

  // Parser states as tracked by the prediction; the RTL encoding is not assumed.
  typedef enum logic [4:0] {
    PS_METHOD_START, PS_METHOD, PS_URI_PATH, PS_URI_KEY, PS_URI_VALUE,
    PS_VER_H, PS_VER_T1, PS_VER_T2, PS_VER_P, PS_VER_SLASH,
    PS_MAJOR_START, PS_MAJOR, PS_MINOR_START, PS_MINOR, PS_NL1,
    PS_LINE_START, PS_LWS, PS_HNAME, PS_SP_BEFORE_VAL, PS_HVALUE,
    PS_NL2, PS_NL3, PS_HELD_GOOD, PS_HELD_BAD
  } parse_state_t;

  logic clk;
  logic rst;

  hrp_in_if  req_ch ();
  hrp_out_if res_ch ();

  http_request_header_parser u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // Control characters: 0..31 and DEL. Bytes with the top bit set are not control.
  function automatic bit ctl_char(input logic [7:0] b);
    return (b < 8'd32) || (b == CH_DEL);
  endfunction

  function automatic bit token_char(input logic [7:0] b);
    if (b[7] || ctl_char(b)) return 1'b0;
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", CH_SP, CH_TAB: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit digit_char(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Append one decimal digit; clamp at 255.
  function automatic logic [7:0] push_digit(input logic [7:0] v, input logic [7:0] b);
    int acc;
    acc = int'(v) * 10 + int'(b - CH_ZERO);
    return (acc > 255) ? 8'd255 : 8'(acc);
  endfunction

  // Tracks the parser's state for every accepted byte and checks the results.
  class http_parse_tracker;
    parse_state_t state;
    logic [7:0]   major_num;
    logic [7:0]   minor_num;
    logic         header_open;
    res_item_t    parse_results_due[$];
    int           mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      state       = PS_METHOD_START;
      major_num   = '0;
      minor_num   = '0;
      header_open = 1'b0;
    endfunction

    function int pending();
      return parse_results_due.size();
    endfunction

    // Advance the tracked state by one accepted request byte and queue its result.
    function void note_byte(input req_item_t it);
      res_item_t  r;
      logic [7:0] b;
      bit         bad;
      b   = it.in_byte;
      bad = 1'b0;
      r.status     = STAT_MORE;
      r.byte_class = CL_DELIM;
      r.new_entry  = 1'b0;
      if (it.cmd == CMD_RESTART) begin
        restart();
        b = '0;
      end else begin
        case (state)
          PS_METHOD_START: begin
            if (token_char(b)) begin
              state = PS_METHOD;
              r.byte_class = CL_METHOD;
            end else bad = 1'b1;
          end
          PS_METHOD: begin
            if (b == CH_SP) state = PS_URI_PATH;
            else if (token_char(b)) r.byte_class = CL_METHOD;
            else bad = 1'b1;
          end
          PS_URI_PATH: begin
            if (b == CH_SP) state = PS_VER_H;
            else if (ctl_char(b)) bad = 1'b1;
            else if (b == CH_QUEST) begin
              state = PS_URI_KEY;
              r.new_entry = 1'b1;
            end else r.byte_class = CL_PATH;
          end
          PS_URI_KEY: begin
            if (b == CH_SP) state = PS_VER_H;
            else if (ctl_char(b)) bad = 1'b1;
            else if (b == CH_EQ) state = PS_URI_VALUE;
            else r.byte_class = CL_KEY;
          end
          PS_URI_VALUE: begin
            if (b == CH_SP) state = PS_VER_H;
            else if (ctl_char(b)) bad = 1'b1;
            else if (b == CH_AMP) begin
              state = PS_URI_KEY;
              r.new_entry = 1'b1;
            end else r.byte_class = CL_VALUE;
          end
          PS_VER_H:  if (b == CH_H) state = PS_VER_T1; else bad = 1'b1;
          PS_VER_T1: if (b == CH_T) state = PS_VER_T2; else bad = 1'b1;
          PS_VER_T2: if (b == CH_T) state = PS_VER_P; else bad = 1'b1;
          PS_VER_P:  if (b == CH_P) state = PS_VER_SLASH; else bad = 1'b1;
          PS_VER_SLASH: begin
            if (b == CH_SLASH) begin
              major_num = '0;
              minor_num = '0;
              state = PS_MAJOR_START;
            end else bad = 1'b1;
          end
          PS_MAJOR_START: begin
            if (digit_char(b)) begin
              major_num = push_digit(major_num, b);
              state = PS_MAJOR;
            end else bad = 1'b1;
          end
          PS_MAJOR: begin
            if (b == CH_DOT) state = PS_MINOR_START;
            else if (digit_char(b)) major_num = push_digit(major_num, b);
            else bad = 1'b1;
          end
          PS_MINOR_START: begin
            if (digit_char(b)) begin
              minor_num = push_digit(minor_num, b);
              state = PS_MINOR;
            end else bad = 1'b1;
          end
          PS_MINOR: begin
            if (b == CH_CR) state = PS_NL1;
            else if (digit_char(b)) minor_num = push_digit(minor_num, b);
            else bad = 1'b1;
          end
          PS_NL1: if (b == CH_LF) state = PS_LINE_START; else bad = 1'b1;
          PS_LINE_START: begin
            if (b == CH_CR) state = PS_NL3;
            else if (header_open && (b == CH_SP || b == CH_TAB)) state = PS_LWS;
            else if (token_char(b)) begin
              header_open  = 1'b1;
              state        = PS_HNAME;
              r.byte_class = CL_HNAME;
              r.new_entry  = 1'b1;
            end else bad = 1'b1;
          end
          PS_LWS: begin
            if (b == CH_CR) state = PS_NL2;
            else if (b == CH_SP || b == CH_TAB) state = PS_LWS;
            else if (ctl_char(b)) bad = 1'b1;
            else begin
              state = PS_HVALUE;
              r.byte_class = CL_HVALUE;
            end
          end
          PS_HNAME: begin
            if (b == CH_COLON) state = PS_SP_BEFORE_VAL;
            else if (token_char(b)) r.byte_class = CL_HNAME;
            else bad = 1'b1;
          end
          PS_SP_BEFORE_VAL: if (b == CH_SP) state = PS_HVALUE; else bad = 1'b1;
          PS_HVALUE: begin
            if (b == CH_CR) state = PS_NL2;
            else if (ctl_char(b)) bad = 1'b1;
            else r.byte_class = CL_HVALUE;
          end
          PS_NL2: if (b == CH_LF) state = PS_LINE_START; else bad = 1'b1;
          PS_NL3: begin
            if (b == CH_LF) begin
              state = PS_HELD_GOOD;
              r.status = STAT_GOOD;
            end else bad = 1'b1;
          end
          PS_HELD_GOOD: r.status = STAT_GOOD;
          default: bad = 1'b1;
        endcase
        if (bad) begin
          state        = PS_HELD_BAD;
          r.status     = STAT_BAD;
          r.byte_class = CL_DELIM;
          r.new_entry  = 1'b0;
        end
      end
      r.out_byte      = b;
      r.major_version = major_num;
      r.minor_version = minor_num;
      parse_results_due.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Match a result against the oldest outstanding prediction.
    function void check_result(input res_item_t got);
      res_item_t want;
      if (parse_results_due.size() == 0) begin
        $error("unexpected result: out_byte %0d with no byte outstanding", got.out_byte);
        mismatches++;
        return;
      end
      want = parse_results_due.pop_front();
      compare_field("status",        8'(want.status),     8'(got.status));
      compare_field("byte_class",    8'(want.byte_class), 8'(got.byte_class));
      compare_field("new_entry",     8'(want.new_entry),  8'(got.new_entry));
      compare_field("out_byte",      want.out_byte,       got.out_byte);
      compare_field("major_version", want.major_version,  got.major_version);
      compare_field("minor_version", want.minor_version,  got.minor_version);
    endfunction
  endclass

  http_parse_tracker tracker = new();

  // Idle percentages for each side; the sender moves through the phases.
  int send_idle;
  int recv_idle;
  bit long_hold_req;
  int sent_count;
  int cycles;

  // Position inside the current request and the byte to garble, -1 for none.
  int req_pos;
  int corrupt_pos;

  // Free-running clock, period 4 ns.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hang guard: end the run if it takes far longer than the slowest clean run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next ready value.
  // A long hold is counted down here, independently of the sender.
  initial begin
    int         hold_left;
    res_item_t  got;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.status        = res_ch.status;
        got.byte_class    = res_ch.byte_class;
        got.new_entry     = res_ch.new_entry;
        got.out_byte      = res_ch.out_byte;
        got.major_version = res_ch.major_version;
        got.minor_version = res_ch.minor_version;
        tracker.check_result(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one transaction after a random idle gap and hold it until accepted.
  // Valid stays high between back-to-back transactions; it drops only for a gap or a drain.
  task automatic send_item(input logic c, input logic [7:0] b);
    req_item_t it;
    int        gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.in_byte <= b;
    it.cmd     = c;
    it.in_byte = b;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_byte(it);
    sent_count++;
  endtask

  // Send one request byte, garbling it if this is the chosen position.
  task automatic feed_byte(input logic [7:0] b);
    if (req_pos == corrupt_pos) b = 8'($urandom_range(255));
    req_pos++;
    send_item(CMD_PARSE, b);
  endtask

  // Random non-control byte from lo..255, never equal to skip.
  function automatic logic [7:0] rand_char(input int lo, input logic [7:0] skip);
    logic [7:0] c;
    do c = 8'($urandom_range(255, lo)); while (ctl_char(c) || c == skip);
    return c;
  endfunction

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 33)); while (!token_char(c));
    return c;
  endfunction

  // Mostly a single digit; now and then a long run to drive saturation.
  task automatic feed_number();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(4, 2) : 1;
    repeat (n) feed_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Well-formed request with random content; a quarter pick one byte position to garble.
  task automatic send_request();
    int hdrs;
    int k;
    send_item(CMD_RESTART, 8'($urandom_range(255)));
    req_pos = 0;
    corrupt_pos = ($urandom_range(99) < 25) ? $urandom_range(60) : -1;

    repeat ($urandom_range(6, 1)) feed_byte(rand_token());
    feed_byte(CH_SP);
    repeat ($urandom_range(6)) feed_byte(rand_char(33, CH_QUEST));
    if ($urandom_range(1)) begin
      k = $urandom_range(3, 1);
      for (int i = 0; i < k; i++) begin
        feed_byte((i == 0) ? CH_QUEST : CH_AMP);
        repeat ($urandom_range(4)) feed_byte(rand_char(33, CH_EQ));
        if ($urandom_range(3) != 0) begin
          feed_byte(CH_EQ);
          repeat ($urandom_range(4)) feed_byte(rand_char(33, CH_AMP));
        end
      end
    end
    feed_byte(CH_SP);
    feed_byte(CH_H);
    feed_byte(CH_T);
    feed_byte(CH_T);
    feed_byte(CH_P);
    feed_byte(CH_SLASH);
    feed_number();
    feed_byte(CH_DOT);
    feed_number();
    feed_byte(CH_CR);
    feed_byte(CH_LF);

    hdrs = $urandom_range(3);
    for (int h = 0; h < hdrs; h++) begin
      // Whitespace before the first header must be rejected as a continuation.
      if (h == 0 && $urandom_range(19) == 0)
        feed_byte($urandom_range(1) ? CH_SP : CH_TAB);
      repeat ($urandom_range(6, 1)) feed_byte(rand_token());
      feed_byte(CH_COLON);
      feed_byte(CH_SP);
      repeat ($urandom_range(8)) feed_byte(rand_char(32, CH_DEL));
      feed_byte(CH_CR);
      feed_byte(CH_LF);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) feed_byte($urandom_range(1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(5)) feed_byte(rand_char(32, CH_DEL));
        feed_byte(CH_CR);
        feed_byte(CH_LF);
      end
    end
    feed_byte(CH_CR);
    feed_byte(CH_LF);
    // A few bytes after the end must repeat the held status.
    repeat ($urandom_range(2)) feed_byte(8'($urandom_range(255)));
  endtask

  // Drop valid and hold off until every predicted result has been checked.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bit in_phase_b;
    bit in_phase_c;
    in_phase_b    = 1'b0;
    in_phase_c    = 1'b0;
    sent_count    = 0;
    long_hold_req = 1'b0;
    send_idle     = 31;
    recv_idle     = 73;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.cmd     <= CMD_PARSE;
    req_ch.in_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: top-bit byte, held bad, restart echo, DEL in the method,
    // bare query delimiters and a version that saturates.
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_PARSE,   8'hFF);
    send_item(CMD_PARSE,   8'h00);
    send_item(CMD_RESTART, 8'hFF);
    send_item(CMD_PARSE,   "G");
    send_item(CMD_PARSE,   CH_DEL);
    send_item(CMD_RESTART, 8'h5A);
    send_item(CMD_PARSE,   "A");
    send_item(CMD_PARSE,   CH_SP);
    send_item(CMD_PARSE,   CH_QUEST);
    send_item(CMD_PARSE,   CH_AMP);
    send_item(CMD_PARSE,   CH_EQ);
    send_item(CMD_PARSE,   CH_SP);
    send_item(CMD_PARSE,   CH_H);
    send_item(CMD_PARSE,   CH_T);
    send_item(CMD_PARSE,   CH_T);
    send_item(CMD_PARSE,   CH_P);
    send_item(CMD_PARSE,   CH_SLASH);
    send_item(CMD_PARSE,   CH_NINE);
    send_item(CMD_PARSE,   CH_NINE);
    send_item(CMD_PARSE,   CH_NINE);
    send_item(CMD_PARSE,   CH_DOT);
    send_item(CMD_PARSE,   CH_NINE);

    // Random: mostly well-formed requests, some bursts of raw noise.
    while (sent_count < ITEM_TARGET) begin
      if (!in_phase_b && sent_count >= PHASE_LEN) begin
        in_phase_b = 1'b1;
        drain_results();
        send_idle = 73;
        recv_idle = 31;
      end
      if (!in_phase_c && sent_count >= 2 * PHASE_LEN) begin
        in_phase_c = 1'b1;
        send_idle = 0;
        recv_idle = 0;
        // Stall the result side for a long stretch so the parser backs up.
        long_hold_req = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(8, 1))
          send_item(($urandom_range(15) == 0) ? CMD_RESTART : CMD_PARSE,
                    8'($urandom_range(255)));
      end else begin
        send_request();
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
